### rtl/core/ite_pkg.sv
package ite_pkg;

    // Default arithmetic format: signed Q16.16
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed port field widths
    localparam int FUNC_W    = 3;
    localparam int OPERAND_W = 32;
    localparam int STATUS_W  = 3;

    // Stack sizes
    localparam int VDEPTH = 4;
    localparam int ODEPTH = 3;
    localparam int VCNT_W = 3;
    localparam int OCNT_W = 2;
    localparam int PREC_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        F_NUM,
        F_ADD,
        F_SUB,
        F_MUL,
        F_DIV,
        F_GE,
        F_LE
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALUE,
        ST_TRUE,
        ST_FALSE,
        ST_BAD,
        ST_DIV_ZERO
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_ALU,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    // Binding strength: mul/div over add over comparison
    function automatic logic [PREC_W-1:0] prec_of(input t_func code);
        logic [PREC_W-1:0] p;
        case (code)
            F_ADD, F_SUB: p = PREC_W'(2);
            F_MUL, F_DIV: p = PREC_W'(3);
            F_GE, F_LE:   p = PREC_W'(1);
            default:      p = '0;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/ite_intf.sv
interface ite_tok_if import ite_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [FUNC_W-1:0]           func;
    logic signed [OPERAND_W-1:0] operand_value;
    logic                        last;

    modport source (output valid, func, operand_value, last, input ready);
    modport sink   (input valid, func, operand_value, last, output ready);
endinterface

interface ite_res_if import ite_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [OPERAND_W-1:0] result_value;
    logic [STATUS_W-1:0]         status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

### rtl/core/ite_alu.sv
// Shared iterative unit: saturating add (one step), shift-add multiply
// (one bit per step), restoring divide (one quotient bit per step).
module ite_alu import ite_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_alu_ctl                      i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_y,
    input  logic signed [VALUE_WIDTH-1:0] i_x,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_result
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int LW   = W + F;
    localparam int HW   = W + 1;
    localparam int AW   = W + 2;
    localparam int MW   = (2 * W > LW) ? 2 * W : LW;
    localparam int CNTW = $clog2(LW + 1);

    localparam logic [W-1:0] VMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN_U = ~VMAX_U;

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    t_alu_op         r_op;
    logic            r_neg;
    logic [HW-1:0]   r_hi;
    logic [LW-1:0]   r_lo;
    logic [W-1:0]    r_opnd;

    logic [W-1:0]    w_mag_y;
    logic [W-1:0]    w_mag_x;
    logic [HW-1:0]   w_shift;
    logic [AW-1:0]   w_a;
    logic [AW-1:0]   w_b;
    logic            w_cin;
    logic [AW-1:0]   w_sum;
    logic            w_fit;
    logic [2*W-1:0]  w_prod;
    logic [MW-1:0]   w_q;
    logic [W-1:0]    w_lim;
    logic [W-1:0]    w_mag;
    logic [W-1:0]    w_md;
    logic [W-1:0]    w_add;

    assign w_mag_y = i_y[W-1] ? W'(-i_y) : W'(i_y);
    assign w_mag_x = i_x[W-1] ? W'(-i_x) : W'(i_x);
    assign w_shift = {r_hi[W-1:0], r_lo[LW-1]};

    // the one adder
    always_comb begin
        case (r_op)
            ALU_MUL: begin
                w_a   = {1'b0, r_hi};
                w_b   = r_lo[F] ? AW'(r_opnd) : '0;
                w_cin = 1'b0;
            end
            ALU_DIV: begin
                w_a   = AW'(w_shift);
                w_b   = ~AW'(r_opnd);
                w_cin = 1'b1;
            end
            default: begin
                w_a   = {r_hi[HW-1], r_hi};
                w_b   = {{2{r_opnd[W-1]}}, r_opnd};
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum = w_a + w_b + AW'(w_cin);
    assign w_fit = ~w_sum[AW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                case (i_ctl.op)
                    ALU_MUL: r_cnt <= CNTW'(W);
                    ALU_DIV: r_cnt <= CNTW'(LW);
                    default: r_cnt <= CNTW'(1);
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_neg <= i_y[W-1] ^ i_x[W-1];
            case (i_ctl.op)
                ALU_MUL: begin
                    r_hi   <= '0;
                    r_opnd <= w_mag_y;
                    r_lo   <= LW'(w_mag_x) << F;
                end
                ALU_DIV: begin
                    r_hi   <= '0;
                    r_opnd <= w_mag_x;
                    r_lo   <= LW'(w_mag_y) << F;
                end
                default: begin
                    r_hi   <= {i_y[W-1], i_y};
                    r_opnd <= i_x;
                end
            endcase
        end else if (r_busy) begin
            case (r_op)
                ALU_MUL: begin
                    r_hi <= w_sum[HW:1];
                    r_lo <= {w_sum[0], r_lo[LW-1:1]};
                end
                ALU_DIV: begin
                    r_hi <= w_fit ? w_sum[HW-1:0] : w_shift;
                    r_lo <= {r_lo[LW-2:0], w_fit};
                end
                default: r_hi <= w_sum[HW-1:0];
            endcase
        end
    end

    // magnitude result, then clamp and sign
    assign w_prod = {r_hi[W-1:0], r_lo[LW-1:F]};
    assign w_q    = (r_op == ALU_MUL) ? MW'(w_prod >> F) : MW'(r_lo);
    assign w_lim  = r_neg ? VMIN_U : VMAX_U;
    assign w_mag  = (w_q > MW'(w_lim)) ? w_lim : w_q[W-1:0];
    assign w_md   = r_neg ? W'(-w_mag) : w_mag;

    assign w_add  = (r_hi[W] ^ r_hi[W-1]) ? (r_hi[W] ? VMIN_U : VMAX_U) : r_hi[W-1:0];

    assign o_result = (r_op == ALU_ADD) ? w_add : w_md;
    assign o_done   = r_done;

endmodule

### rtl/core/infix_token_evaluator_core.sv
// Channel   Dir  Payload                                  Handshake
// i_tok     in   func[2:0], operand_value[31:0], last      valid/ready
// o_res     out  result_value[31:0], status[2:0]           valid/ready
//
// Each operator token is followed by its reductions, up to three. Add, multiply and
// divide (Q16.16 by default) reduce on the shared arithmetic unit; comparison and
// divide by zero are reduced without it. The last token also runs the final
// reductions, which are skipped once an error is flagged.
// Synchronous active-low reset clears counts, flags and the result valid.
// The result sits in an output register; tokens of the next expression are taken
// while it waits, and a new result waits only if that register is full.
module infix_token_evaluator_core import ite_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ite_tok_if.sink   i_tok,
    ite_res_if.source o_res
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = (W > OPERAND_W) ? W : OPERAND_W;

    localparam logic signed [W-1:0]  VMAX_W  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  VMIN_W  = ~VMAX_W;
    localparam logic signed [CW-1:0] VMAX_X  = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] VMIN_X  = ~VMAX_X;
    localparam logic signed [CW-1:0] I32MAX_X = {{(CW-OPERAND_W+1){1'b0}},
                                                 {(OPERAND_W-1){1'b1}}};
    localparam logic signed [CW-1:0] I32MIN_X = ~I32MAX_X;

    // sequencer and stacks
    t_state                r_state, n_state;
    logic signed [W-1:0]   r_vstk [VDEPTH];
    logic signed [W-1:0]   n_vstk [VDEPTH];
    logic [VCNT_W-1:0]     r_vcnt, n_vcnt;
    t_func                 r_ostk [ODEPTH];
    t_func                 n_ostk [ODEPTH];
    logic [OCNT_W-1:0]     r_ocnt, n_ocnt;

    // expression status
    logic                  r_neg_next, n_neg_next;
    logic                  r_cmp_seen, n_cmp_seen;
    logic signed [W-1:0]   r_cmp_right, n_cmp_right;
    t_func                 r_cmp_kind, n_cmp_kind;
    logic                  r_err_bad, n_err_bad;
    logic                  r_err_div, n_err_div;

    // operator token in flight
    t_func                 r_code, n_code;
    logic [PREC_W-1:0]     r_prec, n_prec;
    logic                  r_fin, n_fin;
    logic                  r_last, n_last;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [OPERAND_W-1:0]  r_out_value, n_out_value;
    t_status               r_out_status, n_out_status;

    logic                  w_err;
    logic                  w_is_cmp;
    logic                  w_func_ok;
    t_func                 w_code;
    logic signed [CW-1:0]  w_in_ext;
    logic signed [W-1:0]   w_in_sat;
    logic signed [W-1:0]   w_in_val;
    logic                  w_can_reduce;
    logic signed [CW-1:0]  w_out_ext;
    logic [OPERAND_W-1:0]  w_out32;
    logic [OPERAND_W-1:0]  w_fin_value;
    t_status               w_fin_status;
    t_alu_ctl              w_alu_ctl;
    logic                  w_alu_done;
    logic signed [W-1:0]   w_alu_res;

    ite_alu #(
        .VALUE_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_alu_ctl),
        .i_y      (r_vstk[1]),
        .i_x      (r_vstk[0]),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    assign w_err = r_err_bad | r_err_div;

    // operator decode: subtract goes on the stack as add, negating the next number
    assign w_is_cmp  = (i_tok.func == F_GE) || (i_tok.func == F_LE);
    assign w_func_ok = (i_tok.func inside {F_ADD, F_SUB, F_MUL, F_DIV, F_GE, F_LE})
                       && !(w_is_cmp && r_cmp_seen);
    assign w_code    = (i_tok.func == F_SUB) ? F_ADD : t_func'(i_tok.func);

    // number: widen, clamp to value range, optional saturating negate
    assign w_in_ext = CW'(i_tok.operand_value);
    always_comb begin
        if (w_in_ext > VMAX_X) begin
            w_in_sat = VMAX_W;
        end else if (w_in_ext < VMIN_X) begin
            w_in_sat = VMIN_W;
        end else begin
            w_in_sat = w_in_ext[W-1:0];
        end
    end
    assign w_in_val = !r_neg_next ? w_in_sat :
                      (w_in_sat == VMIN_W) ? VMAX_W : -w_in_sat;

    // top operator reduces if two or more values are stacked and it binds no looser
    assign w_can_reduce = (r_vcnt > VCNT_W'(1)) && (r_ocnt != '0)
                          && (r_prec <= prec_of(r_ostk[0]));

    // final value clamped to the 32-bit result field
    assign w_out_ext = CW'(r_vstk[0]);
    always_comb begin
        if (w_out_ext > I32MAX_X) begin
            w_out32 = I32MAX_X[OPERAND_W-1:0];
        end else if (w_out_ext < I32MIN_X) begin
            w_out32 = I32MIN_X[OPERAND_W-1:0];
        end else begin
            w_out32 = w_out_ext[OPERAND_W-1:0];
        end
    end

    // status priority: bad expression, divide by zero, leftovers, comparison
    always_comb begin
        w_fin_value = '0;
        if (r_err_bad) begin
            w_fin_status = ST_BAD;
        end else if (r_err_div) begin
            w_fin_status = ST_DIV_ZERO;
        end else if (r_ocnt != '0 || r_vcnt != VCNT_W'(1)) begin
            w_fin_status = ST_BAD;
        end else if (r_cmp_seen) begin
            case (r_cmp_kind)
                F_GE:    w_fin_status = (r_vstk[0] >= r_cmp_right) ? ST_TRUE : ST_FALSE;
                F_LE:    w_fin_status = (r_vstk[0] <= r_cmp_right) ? ST_TRUE : ST_FALSE;
                default: w_fin_status = ST_BAD;
            endcase
        end else begin
            w_fin_status = ST_VALUE;
            w_fin_value  = w_out32;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_vstk       = r_vstk;
        n_vcnt       = r_vcnt;
        n_ostk       = r_ostk;
        n_ocnt       = r_ocnt;
        n_neg_next   = r_neg_next;
        n_cmp_seen   = r_cmp_seen;
        n_cmp_right  = r_cmp_right;
        n_cmp_kind   = r_cmp_kind;
        n_err_bad    = r_err_bad;
        n_err_div    = r_err_div;
        n_code       = r_code;
        n_prec       = r_prec;
        n_fin        = r_fin;
        n_last       = r_last;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_alu_ctl.start = 1'b0;
        w_alu_ctl.op    = ALU_ADD;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_tok.valid) begin
                    if (i_tok.func == F_NUM) begin
                        // tokens after an error are dropped until the last one
                        if (!w_err) begin
                            n_neg_next = 1'b0;
                            if (r_vcnt >= VCNT_W'(VDEPTH)) begin
                                n_err_bad = 1'b1;
                            end else begin
                                n_vstk[0] = w_in_val;
                                for (int i = 1; i < VDEPTH; i++) begin
                                    n_vstk[i] = r_vstk[i-1];
                                end
                                n_vcnt = r_vcnt + VCNT_W'(1);
                            end
                        end
                        if (i_tok.last) begin
                            n_state = S_FINISH;
                        end
                    end else if (w_err || !w_func_ok) begin
                        if (!w_err) begin
                            n_err_bad = 1'b1;
                        end
                        // an expression may not end on an operator
                        if (i_tok.last) begin
                            n_err_bad = 1'b1;
                            n_state   = S_DONE;
                        end
                    end else begin
                        if (i_tok.func == F_SUB) begin
                            n_neg_next = 1'b1;
                        end
                        n_code  = w_code;
                        n_prec  = prec_of(w_code);
                        n_fin   = 1'b0;
                        n_last  = i_tok.last;
                        n_state = S_REDUCE;
                    end
                end
            end

            S_FINISH: begin
                n_cmp_kind = F_NUM;
                if (w_err) begin
                    n_state = S_DONE;
                end else begin
                    n_prec  = '0;
                    n_fin   = 1'b1;
                    n_state = S_REDUCE;
                end
            end

            S_REDUCE: begin
                if (w_can_reduce) begin
                    if (r_ostk[0] == F_GE || r_ostk[0] == F_LE) begin
                        // comparison: park the right side, left stays on the stack
                        n_cmp_right = r_vstk[0];
                        if (r_fin) begin
                            n_cmp_kind = r_ostk[0];
                        end
                        for (int i = 0; i < VDEPTH - 1; i++) begin
                            n_vstk[i] = r_vstk[i+1];
                        end
                        n_vcnt = r_vcnt - VCNT_W'(1);
                        for (int i = 0; i < ODEPTH - 1; i++) begin
                            n_ostk[i] = r_ostk[i+1];
                        end
                        n_ocnt = r_ocnt - OCNT_W'(1);
                    end else if (r_ostk[0] == F_DIV && r_vstk[0] == '0) begin
                        // divide by zero: flag it, quotient taken as zero
                        n_err_div = 1'b1;
                        n_vstk[0] = '0;
                        for (int i = 1; i < VDEPTH - 1; i++) begin
                            n_vstk[i] = r_vstk[i+1];
                        end
                        n_vcnt = r_vcnt - VCNT_W'(1);
                        for (int i = 0; i < ODEPTH - 1; i++) begin
                            n_ostk[i] = r_ostk[i+1];
                        end
                        n_ocnt = r_ocnt - OCNT_W'(1);
                    end else begin
                        w_alu_ctl.start = 1'b1;
                        case (r_ostk[0])
                            F_MUL:   w_alu_ctl.op = ALU_MUL;
                            F_DIV:   w_alu_ctl.op = ALU_DIV;
                            default: w_alu_ctl.op = ALU_ADD;
                        endcase
                        n_state = S_ALU;
                    end
                end else if (r_fin) begin
                    n_state = S_DONE;
                end else begin
                    if (r_code == F_GE || r_code == F_LE) begin
                        n_cmp_seen = 1'b1;
                    end
                    if (r_ocnt >= OCNT_W'(ODEPTH)) begin
                        n_err_bad = 1'b1;
                    end else begin
                        n_ostk[0] = r_code;
                        for (int i = 1; i < ODEPTH; i++) begin
                            n_ostk[i] = r_ostk[i-1];
                        end
                        n_ocnt = r_ocnt + OCNT_W'(1);
                    end
                    if (r_last) begin
                        n_err_bad = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_ALU: begin
                // pop two values, push the result, pop the operator
                if (w_alu_done) begin
                    n_vstk[0] = w_alu_res;
                    for (int i = 1; i < VDEPTH - 1; i++) begin
                        n_vstk[i] = r_vstk[i+1];
                    end
                    n_vcnt = r_vcnt - VCNT_W'(1);
                    for (int i = 0; i < ODEPTH - 1; i++) begin
                        n_ostk[i] = r_ostk[i+1];
                    end
                    n_ocnt  = r_ocnt - OCNT_W'(1);
                    n_state = S_REDUCE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = w_fin_value;
                    n_out_status = w_fin_status;
                    n_vcnt       = '0;
                    n_ocnt       = '0;
                    n_neg_next   = 1'b0;
                    n_cmp_seen   = 1'b0;
                    n_err_bad    = 1'b0;
                    n_err_div    = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcnt      <= '0;
            r_ocnt      <= '0;
            r_neg_next  <= 1'b0;
            r_cmp_seen  <= 1'b0;
            r_cmp_kind  <= F_NUM;
            r_err_bad   <= 1'b0;
            r_err_div   <= 1'b0;
            r_prec      <= '0;
            r_fin       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcnt      <= n_vcnt;
            r_ocnt      <= n_ocnt;
            r_neg_next  <= n_neg_next;
            r_cmp_seen  <= n_cmp_seen;
            r_cmp_kind  <= n_cmp_kind;
            r_err_bad   <= n_err_bad;
            r_err_div   <= n_err_div;
            r_prec      <= n_prec;
            r_fin       <= n_fin;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vstk       <= n_vstk;
        r_ostk       <= n_ostk;
        r_cmp_right  <= n_cmp_right;
        r_code       <= n_code;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_tok.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.status       = r_out_status;

endmodule

### rtl/core/ite_checker.sv
module ite_checker import ite_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_tok_ready,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [OPERAND_W-1:0] i_res_value,
    input logic [STATUS_W-1:0]  i_res_status
);

    // reset empties the output and returns the sequencer to idle
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && i_tok_ready)
        else $error("output valid or busy after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_value) && $stable(i_res_status))
        else $error("stalled result changed");

    // comparisons and errors carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status != ST_VALUE) |-> i_res_value == '0)
        else $error("nonzero value with non-value status");

    // a fresh result is loaded only as the sequencer goes back to idle
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> i_tok_ready)
        else $error("result appeared while still evaluating");

endmodule

bind infix_token_evaluator_core ite_checker u_ite_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tok_ready  (i_tok.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_value  (o_res.result_value),
    .i_res_status (o_res.status)
);
